>>> design/cbps_pkg.sv
// Package for the cubic Bezier point sampler: register indexes, reset values,
// fixed field widths and the geometry settings shared between the modules.
// No dependencies.
package cbps_pkg;

    localparam int STEP_W      = 4;
    localparam int FRAME_W     = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int QUEUE_DEPTH = 4;
    localparam int PIPE_STAGES = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_SHIFT   = 2'd0,
        CFG_FRAME_WIDTH  = 2'd1,
        CFG_FRAME_HEIGHT = 2'd2
    } t_cfg_idx;

    localparam logic [STEP_W-1:0]  RST_STEP_SHIFT   = 4'd10;
    localparam logic [FRAME_W-1:0] RST_FRAME_WIDTH  = 13'd640;
    localparam logic [FRAME_W-1:0] RST_FRAME_HEIGHT = 13'd480;

    // Effective settings seen by the datapath.
    typedef struct packed {
        logic [STEP_W-1:0]  shift;
        logic [FRAME_W-1:0] frame_w;
        logic [FRAME_W-1:0] frame_h;
    } t_geom;

endpackage

>>> design/cbps_front.sv
// Front end of the sampler: takes input words, clamps the sample index and
// packs each word for the queue. Depends on cbps_pkg.
module cbps_front #(
    parameter int COORD_BITS     = 12,
    parameter int MAX_STEP_SHIFT = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cbps_pkg::t_geom               i_geom,
    input  logic                          i_valid,
    input  logic [COORD_BITS-1:0]         i_x_p0,
    input  logic [COORD_BITS-1:0]         i_y_p0,
    input  logic [COORD_BITS-1:0]         i_x_p1,
    input  logic [COORD_BITS-1:0]         i_y_p1,
    input  logic [COORD_BITS-1:0]         i_x_p2,
    input  logic [COORD_BITS-1:0]         i_y_p2,
    input  logic [COORD_BITS-1:0]         i_x_p3,
    input  logic [COORD_BITS-1:0]         i_y_p3,
    input  logic [MAX_STEP_SHIFT:0]       i_sample_index,
    input  logic                          i_q_full,
    output logic                          o_stall,
    output logic                          o_push,
    output logic [1+2*(MAX_STEP_SHIFT+1)+8*COORD_BITS-1:0] o_entry
);
    import cbps_pkg::*;

    localparam int IW = MAX_STEP_SHIFT + 1;

    logic          r_alive;
    logic [IW-1:0] n_steps;
    logic [IW-1:0] idx_clamped;
    logic [IW-1:0] idx_rest;
    logic          is_last;

    // Holds the input stalled during reset and until the registered flag r_alive is set after release.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive <= 1'b0;
        end else begin
            r_alive <= 1'b1;
        end
    end

    always_comb begin
        n_steps     = IW'(1) << i_geom.shift;
        is_last     = (i_sample_index >= n_steps);
        idx_clamped = is_last ? n_steps : i_sample_index;
        idx_rest    = n_steps - idx_clamped;
    end

    assign o_stall = !r_alive || i_q_full;
    assign o_push  = i_valid && !o_stall;
    assign o_entry = {is_last, idx_rest, idx_clamped,
                      i_y_p3, i_x_p3, i_y_p2, i_x_p2,
                      i_y_p1, i_x_p1, i_y_p0, i_x_p0};

endmodule

>>> design/cbps_queue.sv
// Short first-in first-out queue of flip-flops between front and back end.
// No dependencies.
module cbps_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output logic             o_full,
    output logic [WIDTH-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;
    logic [AW-1:0]    n_wr;
    logic [AW-1:0]    n_rd;
    logic [CW-1:0]    n_cnt;

    always_comb begin
        n_wr  = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        n_rd  = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        n_cnt = r_cnt + CW'(i_push) - CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_data  = r_mem[r_rd];

endmodule

>>> design/cbps_back.sv
// Back end of the sampler: Bernstein weights, weighted sums, rounding and
// frame test in a six-stage pipeline that stalls as one. Depends on cbps_pkg.
module cbps_back #(
    parameter int COORD_BITS     = 12,
    parameter int MAX_STEP_SHIFT = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  cbps_pkg::t_geom       i_geom,
    input  logic                  i_q_valid,
    input  logic [1+2*(MAX_STEP_SHIFT+1)+8*COORD_BITS-1:0] i_q_data,
    output logic                  o_q_pop,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic                  o_inside_frame,
    output logic                  o_last_sample
);
    import cbps_pkg::*;

    localparam int C    = COORD_BITS;
    localparam int IW   = MAX_STEP_SHIFT + 1;
    localparam int WW   = 3 * MAX_STEP_SHIFT + 1;
    localparam int SW   = 3 * MAX_STEP_SHIFT + COORD_BITS;
    localparam int SH_W = $clog2(3 * MAX_STEP_SHIFT + 1);
    localparam int CMP_W = (C > FRAME_W) ? C : FRAME_W;

    logic en;

    // Stage 1: squares.
    logic            r1_v, r1_last;
    logic [IW-1:0]   r1_u, r1_i;
    logic [2*IW-1:0] r1_u2, r1_i2;
    logic [C-1:0]    r1_p [2][4];
    // Stage 2: the four cube weights.
    logic            r2_v, r2_last;
    logic [WW-1:0]   r2_w [4];
    logic [C-1:0]    r2_p [2][4];
    // Stage 3: weighted terms per axis.
    logic            r3_v, r3_last;
    logic [SW-1:0]   r3_t [2][4];
    // Stage 4: partial sums.
    logic            r4_v, r4_last;
    logic [SW-1:0]   r4_a [2];
    logic [SW-1:0]   r4_b [2];
    // Stage 5: rounded pixels.
    logic            r5_v, r5_last;
    logic [C-1:0]    r5_pix [2];
    // Stage 6: output word.
    logic            r6_v;

    logic [3*IW-1:0] w_prod [4];
    logic [WW+C-1:0] t_prod [2][4];
    logic [SH_W-1:0] sh;
    logic [SW-1:0]   half;
    logic [SW-1:0]   sum [2];

    assign en      = !r6_v || !i_stall;
    assign o_q_pop = en && i_q_valid;

    always_comb begin
        w_prod[0] = r1_u2 * r1_u;
        w_prod[1] = r1_u2 * r1_i;
        w_prod[2] = r1_i2 * r1_u;
        w_prod[3] = r1_i2 * r1_i;
        for (int a = 0; a < 2; a++) begin
            for (int k = 0; k < 4; k++) begin
                t_prod[a][k] = r2_w[k] * r2_p[a][k];
            end
        end
        sh   = SH_W'({i_geom.shift, 1'b0}) + SH_W'(i_geom.shift);
        half = SW'(1) << (sh - SH_W'(1));
        for (int a = 0; a < 2; a++) begin
            sum[a] = r4_a[a] + r4_b[a] + half;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_q_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_last <= i_q_data[1+2*IW+8*C-1];
            r1_u    <= i_q_data[8*C+IW +: IW];
            r1_i    <= i_q_data[8*C +: IW];
            r1_u2   <= i_q_data[8*C+IW +: IW] * i_q_data[8*C+IW +: IW];
            r1_i2   <= i_q_data[8*C +: IW] * i_q_data[8*C +: IW];
            for (int a = 0; a < 2; a++) begin
                for (int k = 0; k < 4; k++) begin
                    r1_p[a][k] <= i_q_data[(2*k+a)*C +: C];
                end
            end

            r2_last <= r1_last;
            for (int k = 0; k < 4; k++) begin
                r2_w[k] <= w_prod[k][WW-1:0];
            end
            r2_p <= r1_p;

            r3_last <= r2_last;
            for (int a = 0; a < 2; a++) begin
                for (int k = 0; k < 4; k++) begin
                    r3_t[a][k] <= t_prod[a][k][SW-1:0];
                end
            end

            // The middle weights carry the factor three: 3t = 2t + t.
            r4_last <= r3_last;
            for (int a = 0; a < 2; a++) begin
                r4_a[a] <= r3_t[a][0] + {r3_t[a][1][SW-2:0], 1'b0} + r3_t[a][1];
                r4_b[a] <= r3_t[a][3] + {r3_t[a][2][SW-2:0], 1'b0} + r3_t[a][2];
            end

            r5_last <= r4_last;
            for (int a = 0; a < 2; a++) begin
                r5_pix[a] <= C'(sum[a] >> sh);
            end

            o_last_sample  <= r5_last;
            o_pixel_x      <= r5_pix[0];
            o_pixel_y      <= r5_pix[1];
            o_inside_frame <= (CMP_W'(r5_pix[0]) < CMP_W'(i_geom.frame_w)) &&
                              (CMP_W'(r5_pix[1]) < CMP_W'(i_geom.frame_h));
        end
    end

    assign o_valid = r6_v;

endmodule

>>> design/cubic_bezier_point_sampler_unit.sv
// A word accepted at the input is written into the queue and then flows through the back end.
// Throughput: one word per cycle, as every back-end stage takes a new word each cycle; a held
// result freezes the back end, and the input stalls once the four-word queue has filled.
// Reset (synchronous, active low) clears the registers to step_shift 10 and a 640 x 480 frame,
// empties the queue and the pipeline, and holds o_stall high until the front end's r_alive is set.
module cubic_bezier_point_sampler_unit #(
    parameter int COORD_BITS     = 12,
    parameter int MAX_STEP_SHIFT = 12
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cbps_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cbps_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [COORD_BITS-1:0]          i_x_p0,
    input  logic [COORD_BITS-1:0]          i_y_p0,
    input  logic [COORD_BITS-1:0]          i_x_p1,
    input  logic [COORD_BITS-1:0]          i_y_p1,
    input  logic [COORD_BITS-1:0]          i_x_p2,
    input  logic [COORD_BITS-1:0]          i_y_p2,
    input  logic [COORD_BITS-1:0]          i_x_p3,
    input  logic [COORD_BITS-1:0]          i_y_p3,
    input  logic [MAX_STEP_SHIFT:0]        i_sample_index,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [COORD_BITS-1:0]          o_pixel_x,
    output logic [COORD_BITS-1:0]          o_pixel_y,
    output logic                           o_inside_frame,
    output logic                           o_last_sample
);
    import cbps_pkg::*;

    // The sample index is clamped to N = 2^s and its complement N - i is
    // formed in the front end. The back end then computes the exact sum
    //   (N-i)^3 P0 + 3 (N-i)^2 i P1 + 3 (N-i) i^2 P2 + i^3 P3
    // for both axes and rounds it half up by a shift of 3s. Since the
    // weights add up to N^3, every partial sum fits in 3*MAX_STEP_SHIFT +
    // COORD_BITS bits without overflow.

    localparam int EW = 1 + 2 * (MAX_STEP_SHIFT + 1) + 8 * COORD_BITS;

    logic [STEP_W-1:0]  r_step_shift;
    logic [FRAME_W-1:0] r_frame_width;
    logic [FRAME_W-1:0] r_frame_height;
    t_geom              geom;

    logic          q_push;
    logic          q_pop;
    logic          q_valid;
    logic          q_full;
    logic [EW-1:0] q_in;
    logic [EW-1:0] q_out;

    // Configuration registers. Writes to an unused index are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_shift   <= RST_STEP_SHIFT;
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_STEP_SHIFT: begin
                    r_step_shift <= i_cfg_data[STEP_W-1:0];
                end
                CFG_FRAME_WIDTH: begin
                    r_frame_width <= i_cfg_data[FRAME_W-1:0];
                end
                CFG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg_data[FRAME_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // A step shift of zero behaves as one, and anything above the largest
    // supported shift is held at that shift. The user must change the registers only while
    // the block is idle, as both ends read these settings live; nothing here enforces it.
    always_comb begin
        if (r_step_shift == '0) begin
            geom.shift = STEP_W'(1);
        end else if ({1'b0, r_step_shift} > (STEP_W + 1)'(MAX_STEP_SHIFT)) begin
            geom.shift = STEP_W'(MAX_STEP_SHIFT);
        end else begin
            geom.shift = r_step_shift;
        end
        geom.frame_w = r_frame_width;
        geom.frame_h = r_frame_height;
    end

    // The front end accepts one word per cycle as long as it is out of reset and the queue has room.
    cbps_front #(
        .COORD_BITS     (COORD_BITS),
        .MAX_STEP_SHIFT (MAX_STEP_SHIFT)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_geom         (geom),
        .i_valid        (i_valid),
        .i_x_p0         (i_x_p0),
        .i_y_p0         (i_y_p0),
        .i_x_p1         (i_x_p1),
        .i_y_p1         (i_y_p1),
        .i_x_p2         (i_x_p2),
        .i_y_p2         (i_y_p2),
        .i_x_p3         (i_x_p3),
        .i_y_p3         (i_y_p3),
        .i_sample_index (i_sample_index),
        .i_q_full       (q_full),
        .o_stall        (o_stall),
        .o_push         (q_push),
        .o_entry        (q_in)
    );

    // The queue lets the input side keep going while the result side stalls.
    cbps_queue #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_data  (q_out)
    );

    // The back end freezes as a whole only when its output word is held.
    cbps_back #(
        .COORD_BITS     (COORD_BITS),
        .MAX_STEP_SHIFT (MAX_STEP_SHIFT)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_geom         (geom),
        .i_q_valid      (q_valid),
        .i_q_data       (q_out),
        .o_q_pop        (q_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_inside_frame (o_inside_frame),
        .o_last_sample  (o_last_sample)
    );

endmodule

>>> design/cbps_checker.sv
// Port-level checks for the cubic Bezier point sampler, attached by a bind
// statement at the end of this file. Depends on cbps_pkg.
module cbps_checker #(
    parameter int COORD_BITS     = 12,
    parameter int MAX_STEP_SHIFT = 12
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_stall,
    input logic                  o_valid,
    input logic                  i_stall,
    input logic [COORD_BITS-1:0] o_pixel_x,
    input logic [COORD_BITS-1:0] o_pixel_y,
    input logic                  o_inside_frame,
    input logic                  o_last_sample
);
    import cbps_pkg::*;

    localparam int CAPACITY = QUEUE_DEPTH + PIPE_STAGES;
    localparam int FW       = $clog2(CAPACITY + 1);

    logic          in_acc;
    logic          out_acc;
    logic [FW-1:0] r_inflight;

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;

    // Words accepted but not yet delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + FW'(in_acc) - FW'(out_acc);
        end
    end

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_stall)
        else $error("output valid or input open straight after reset");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_pixel_x) && $stable(o_pixel_y)
            && $stable(o_inside_frame) && $stable(o_last_sample))
        else $error("held result word changed");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_inflight != '0)
        else $error("result word without an accepted input word");

    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= FW'(CAPACITY))
        else $error("more words in flight than queue and pipeline hold");

endmodule

bind cubic_bezier_point_sampler_unit cbps_checker #(
    .COORD_BITS     (COORD_BITS),
    .MAX_STEP_SHIFT (MAX_STEP_SHIFT)
) u_cbps_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_pixel_x      (o_pixel_x),
    .o_pixel_y      (o_pixel_y),
    .o_inside_frame (o_inside_frame),
    .o_last_sample  (o_last_sample)
);

>>> bench/cubic_bezier_point_sampler_checker.sv
// Checker for the cubic Bezier point sampler: it follows the configuration port and both
// word channels, predicts each result word and compares it field by field.
// Depends on cbps_pkg for the register indexes, reset values and field widths.
`timescale 1ns / 1ps

module cubic_bezier_point_sampler_checker #(
    parameter int COORD_BITS     = 12,
    parameter int MAX_STEP_SHIFT = 12
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [cbps_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cbps_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  logic [COORD_BITS-1:0]           i_x_p0,
    input  logic [COORD_BITS-1:0]           i_y_p0,
    input  logic [COORD_BITS-1:0]           i_x_p1,
    input  logic [COORD_BITS-1:0]           i_y_p1,
    input  logic [COORD_BITS-1:0]           i_x_p2,
    input  logic [COORD_BITS-1:0]           i_y_p2,
    input  logic [COORD_BITS-1:0]           i_x_p3,
    input  logic [COORD_BITS-1:0]           i_y_p3,
    input  logic [MAX_STEP_SHIFT:0]         i_sample_index,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  logic [COORD_BITS-1:0]           i_pixel_x,
    input  logic [COORD_BITS-1:0]           i_pixel_y,
    input  logic                            i_inside_frame,
    input  logic                            i_last_sample,
    output int unsigned                     o_fail_count,
    output int unsigned                     o_pending
);

    import cbps_pkg::*;

    typedef struct packed {
        logic [COORD_BITS-1:0] px;
        logic [COORD_BITS-1:0] py;
        logic                  in_frame;
        logic                  last;
    } t_curve_pixel;

    t_curve_pixel       expected_pixels[$];
    logic [STEP_W-1:0]  step_shift_q = RST_STEP_SHIFT;
    logic [FRAME_W-1:0] frame_w_q    = RST_FRAME_WIDTH;
    logic [FRAME_W-1:0] frame_h_q    = RST_FRAME_HEIGHT;
    int unsigned        mismatches   = 0;

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    // Exact Bernstein sum at scale 2^(3s), rounded half up to a whole pixel.
    function automatic logic [COORD_BITS-1:0] bernstein_axis(
        input logic [COORD_BITS-1:0] p0, input logic [COORD_BITS-1:0] p1,
        input logic [COORD_BITS-1:0] p2, input logic [COORD_BITS-1:0] p3,
        input logic [63:0] u, input logic [63:0] t, input int unsigned sh);
        logic [63:0] acc;
        acc = u * u * u * 64'(p0) + 64'd3 * u * u * t * 64'(p1)
            + 64'd3 * u * t * t * 64'(p2) + t * t * t * 64'(p3);
        acc = acc + (64'd1 << (sh - 1));
        return COORD_BITS'(acc >> sh);
    endfunction

    function automatic t_curve_pixel predict_pixel();
        t_curve_pixel res;
        int unsigned  s;
        logic [63:0]  n;
        logic [63:0]  t;
        s = step_shift_q;
        if (s < 1) s = 1;
        if (s > MAX_STEP_SHIFT) s = MAX_STEP_SHIFT;
        n = 64'd1 << s;
        t = 64'(i_sample_index);
        if (t > n) t = n;
        res.px       = bernstein_axis(i_x_p0, i_x_p1, i_x_p2, i_x_p3, n - t, t, 3 * s);
        res.py       = bernstein_axis(i_y_p0, i_y_p1, i_y_p2, i_y_p3, n - t, t, 3 * s);
        res.in_frame = (FRAME_W'(res.px) < frame_w_q) && (FRAME_W'(res.py) < frame_h_q);
        res.last     = (t == n);
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_curve_pixel want;
        if (!i_rst_n) begin
            step_shift_q = RST_STEP_SHIFT;
            frame_w_q    = RST_FRAME_WIDTH;
            frame_h_q    = RST_FRAME_HEIGHT;
            expected_pixels.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_STEP_SHIFT:   step_shift_q = i_cfg_data[STEP_W-1:0];
                    CFG_FRAME_WIDTH:  frame_w_q    = i_cfg_data[FRAME_W-1:0];
                    CFG_FRAME_HEIGHT: frame_h_q    = i_cfg_data[FRAME_W-1:0];
                    default: ;
                endcase
            end
            // Results are retired before new words are predicted, so a result in the
            // same cycle as an empty queue is still caught as unexpected.
            if (i_out_valid && !i_out_stall) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch("result word arrived with no expectation waiting");
                end else begin
                    want = expected_pixels.pop_front();
                    if (i_pixel_x !== want.px)
                        report_mismatch($sformatf("pixel_x got %0d expected %0d",
                                                  i_pixel_x, want.px));
                    if (i_pixel_y !== want.py)
                        report_mismatch($sformatf("pixel_y got %0d expected %0d",
                                                  i_pixel_y, want.py));
                    if (i_inside_frame !== want.in_frame)
                        report_mismatch($sformatf("inside_frame got %0b expected %0b",
                                                  i_inside_frame, want.in_frame));
                    if (i_last_sample !== want.last)
                        report_mismatch($sformatf("last_sample got %0b expected %0b",
                                                  i_last_sample, want.last));
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_pixels = {expected_pixels, predict_pixel()};
        end
        o_pending    <= expected_pixels.size();
        o_fail_count <= mismatches;
    end

endmodule

>>> bench/cubic_bezier_point_sampler_unit_tb.sv
// Top level of the testbench for the cubic Bezier point sampler: clock, reset, stimulus
// and verdict. Depends on cbps_pkg, the sampler itself and the checker module.
`timescale 1ns / 1ps

module cubic_bezier_point_sampler_unit_tb;

    import cbps_pkg::*;

    localparam int COORD_BITS     = 12;
    localparam int MAX_STEP_SHIFT = 12;
    localparam int PHASES         = 8;
    localparam int PHASE_WORDS    = 88;

    logic                      i_clk;
    logic                      i_rst_n   = 1'b0;
    logic                      cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_idx   = '0;
    logic [CFG_DATA_W-1:0]     cfg_data  = '0;
    logic                      in_valid  = 1'b0;
    logic                      in_stall;
    logic [COORD_BITS-1:0]     x_p0 = '0, y_p0 = '0, x_p1 = '0, y_p1 = '0;
    logic [COORD_BITS-1:0]     x_p2 = '0, y_p2 = '0, x_p3 = '0, y_p3 = '0;
    logic [MAX_STEP_SHIFT:0]   sample_index = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [COORD_BITS-1:0]     pixel_x, pixel_y;
    logic                      inside_frame, last_sample;
    int unsigned               fail_count, pending_words;

    // Percentages of cycles in which the sender idles and the receiver stalls.
    int unsigned               idle_pct  = 0;
    int unsigned               stall_pct = 0;
    // Step shift as last written, kept only to aim the random sample indexes.
    int unsigned               cur_shift = RST_STEP_SHIFT;

    cubic_bezier_point_sampler_unit #(
        .COORD_BITS     (COORD_BITS),
        .MAX_STEP_SHIFT (MAX_STEP_SHIFT)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_valid        (in_valid),
        .o_stall        (in_stall),
        .i_x_p0         (x_p0),
        .i_y_p0         (y_p0),
        .i_x_p1         (x_p1),
        .i_y_p1         (y_p1),
        .i_x_p2         (x_p2),
        .i_y_p2         (y_p2),
        .i_x_p3         (x_p3),
        .i_y_p3         (y_p3),
        .i_sample_index (sample_index),
        .o_valid        (out_valid),
        .i_stall        (out_stall),
        .o_pixel_x      (pixel_x),
        .o_pixel_y      (pixel_y),
        .o_inside_frame (inside_frame),
        .o_last_sample  (last_sample)
    );

    cubic_bezier_point_sampler_checker #(
        .COORD_BITS     (COORD_BITS),
        .MAX_STEP_SHIFT (MAX_STEP_SHIFT)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_x_p0         (x_p0),
        .i_y_p0         (y_p0),
        .i_x_p1         (x_p1),
        .i_y_p1         (y_p1),
        .i_x_p2         (x_p2),
        .i_y_p2         (y_p2),
        .i_x_p3         (x_p3),
        .i_y_p3         (y_p3),
        .i_sample_index (sample_index),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_pixel_x      (pixel_x),
        .i_pixel_y      (pixel_y),
        .i_inside_frame (inside_frame),
        .i_last_sample  (last_sample),
        .o_fail_count   (fail_count),
        .o_pending      (pending_words)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // The receiver decides afresh at every falling edge whether to stall the result
    // channel, so stalls land on every stage of the pipeline's work.
    always @(negedge i_clk)
        out_stall <= ($urandom_range(99, 0) < stall_pct);

    // Guard against a hung handshake. The slowest correct run is well under a tenth
    // of this, even with every word waiting out long stalls on both sides.
    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Writes one configuration register. The caller has made sure the block is idle.
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        if (idx == CFG_STEP_SHIFT)
            cur_shift = value[STEP_W-1:0];
    endtask

    // Lowers valid and holds off until every predicted result word has come back.
    // The pending count is read at the falling edge, well clear of the checker's update.
    task automatic wait_drain();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending_words != 0)
            @(negedge i_clk);
    endtask

    // Offers one segment word, after a random idle gap, and returns on the rising edge
    // that accepts it. Valid stays high into the next word unless a gap follows, so it
    // is never lowered and raised within one time step.
    task automatic send_segment(
        input logic [COORD_BITS-1:0] ax0, input logic [COORD_BITS-1:0] ay0,
        input logic [COORD_BITS-1:0] ax1, input logic [COORD_BITS-1:0] ay1,
        input logic [COORD_BITS-1:0] ax2, input logic [COORD_BITS-1:0] ay2,
        input logic [COORD_BITS-1:0] ax3, input logic [COORD_BITS-1:0] ay3,
        input logic [MAX_STEP_SHIFT:0] idx);
        @(negedge i_clk);
        while ($urandom_range(99, 0) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid     <= 1'b1;
        x_p0         <= ax0;
        y_p0         <= ay0;
        x_p1         <= ax1;
        y_p1         <= ay1;
        x_p2         <= ax2;
        y_p2         <= ay2;
        x_p3         <= ax3;
        y_p3         <= ay3;
        sample_index <= idx;
        do @(posedge i_clk); while (in_stall);
    endtask

    // Coordinates from several ranges: the full span, a lower quarter, the very small
    // values that small frames need to see both sides of the border, and the extremes.
    function automatic logic [COORD_BITS-1:0] rand_coord(input int unsigned mode);
        case (mode)
            0: return COORD_BITS'($urandom_range(4095, 0));
            1: return COORD_BITS'($urandom_range(1023, 0));
            2: return COORD_BITS'($urandom_range(40, 0));
            default: return ($urandom_range(1, 0) != 0) ? '1 : '0;
        endcase
    endfunction

    // Sample indexes mostly within the segment, with the two ends and the clamped
    // range beyond the end point drawn on purpose.
    function automatic logic [MAX_STEP_SHIFT:0] rand_index();
        int unsigned s;
        int unsigned n;
        int unsigned pick;
        s = cur_shift;
        if (s < 1) s = 1;
        if (s > MAX_STEP_SHIFT) s = MAX_STEP_SHIFT;
        n = 1 << s;
        pick = $urandom_range(99, 0);
        if (pick < 78)
            return (MAX_STEP_SHIFT + 1)'($urandom_range(n, 0));
        else if (pick < 88)
            return (MAX_STEP_SHIFT + 1)'(($urandom_range(1, 0) != 0) ? n : 0);
        else
            return (MAX_STEP_SHIFT + 1)'($urandom_range(8191, n));
    endfunction

    initial begin : stimulus
        int unsigned phase_shift[PHASES]  = '{1, 12, 0, 15, 4, 7, 13, 10};
        int unsigned phase_width[PHASES]  = '{4096, 1, 0, 8191, 1000, 33, 4095, 640};
        int unsigned phase_height[PHASES] = '{4096, 1, 8191, 0, 700, 17, 2, 4096};
        int unsigned mode;

        // Reset is held from time zero and released at a falling edge.
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words at the reset settings: step shift 10 and a 640 x 480 frame.
        // Flat and full-scale segments, both ends of t, the clamp beyond the end point,
        // a point each side of the frame border, and alternating bit patterns.
        send_segment('0, '0, '0, '0, '0, '0, '0, '0, 13'd0);
        send_segment('1, '1, '1, '1, '1, '1, '1, '1, 13'd0);
        send_segment('1, '1, '1, '1, '1, '1, '1, '1, 13'd1024);
        send_segment('1, '1, '1, '1, '1, '1, '1, '1, 13'd8191);
        send_segment(12'd0, 12'd4095, 12'd0, 12'd4095, 12'd4095, 12'd0,
                     12'd4095, 12'd0, 13'd512);
        send_segment(12'd0, 12'd4095, 12'd0, 12'd4095, 12'd4095, 12'd0,
                     12'd4095, 12'd0, 13'd1);
        send_segment(12'd0, 12'd4095, 12'd0, 12'd4095, 12'd4095, 12'd0,
                     12'd4095, 12'd0, 13'd1023);
        send_segment(12'd0, 12'd4095, 12'd0, 12'd4095, 12'd4095, 12'd0,
                     12'd4095, 12'd0, 13'd1025);
        send_segment(12'd0, 12'd4095, 12'd0, 12'd4095, 12'd4095, 12'd0,
                     12'd4095, 12'd0, 13'd4096);
        send_segment(12'd0, 12'd4095, 12'd4095, 12'd0, 12'd0, 12'd4095,
                     12'd4095, 12'd0, 13'd256);
        send_segment(12'd639, 12'd479, 12'd639, 12'd479, 12'd639, 12'd479,
                     12'd639, 12'd479, 13'd300);
        send_segment(12'd640, 12'd479, 12'd640, 12'd479, 12'd640, 12'd479,
                     12'd640, 12'd479, 13'd300);
        send_segment(12'd639, 12'd480, 12'd639, 12'd480, 12'd639, 12'd480,
                     12'd639, 12'd480, 13'd700);
        send_segment(12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA, 12'h555,
                     12'hAAA, 12'h555, 13'h1555);
        send_segment(12'h555, 12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA,
                     12'h555, 12'hAAA, 13'h0AAA);
        send_segment(12'd4, 12'd1, 12'd0, 12'd2, 12'd0, 12'd0, 12'd0, 12'd3, 13'd1);

        // Random phases. Each one drains the pipeline, rewrites all three registers
        // and then runs under its own idling pattern: none, a mostly idle sender, a
        // mostly stalling receiver, and light idling on both sides. The settings take
        // in the shortest and longest steps, both out-of-range step shifts, and frames
        // of zero, one and full size.
        for (int p = 0; p < PHASES; p++) begin
            wait_drain();
            write_reg(CFG_STEP_SHIFT, CFG_DATA_W'(phase_shift[p]));
            write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(phase_width[p]));
            write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(phase_height[p]));
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 83; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 83; end
                default: begin idle_pct = 19; stall_pct = 19; end
            endcase
            for (int k = 0; k < PHASE_WORDS; k++) begin
                mode = $urandom_range(3, 0);
                send_segment(rand_coord(mode), rand_coord(mode), rand_coord(mode),
                             rand_coord(mode), rand_coord(mode), rand_coord(mode),
                             rand_coord(mode), rand_coord(mode), rand_index());
            end
        end

        // Let the last words come out and watch for anything stray before giving the verdict.
        wait_drain();
        stall_pct = 0;
        repeat (4 * PIPE_STAGES) @(negedge i_clk);
        if (fail_count == 0 && pending_words == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
